### sv/limit_switch_debounce_quad_assert.svh
// ---------------------------------------------------------------------------
// Limit switch debounce assertion macros
// Shared concurrent assertion forms, clocked on the rising edge and
// disabled during reset.
// ---------------------------------------------------------------------------
`ifndef LIMIT_SWITCH_DEBOUNCE_QUAD_ASSERT_SVH
`define LIMIT_SWITCH_DEBOUNCE_QUAD_ASSERT_SVH

// same-cycle implication
`define LSDQ_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lsdq: implication check failed");

// next-cycle implication
`define LSDQ_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lsdq: next-cycle check failed");

// condition that must never hold
`define LSDQ_ASSERT_NEVER(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("lsdq: forbidden condition seen");

`endif

### sv/lsdq_pkg.sv
// ---------------------------------------------------------------------------
// Limit switch debounce package
// Shared types and constants for the four-channel limit switch debouncer.
// ---------------------------------------------------------------------------
package lsdq_pkg;

  localparam int TIMESTAMP_BITS_DEFAULT = 32;
  localparam int CH_COUNT               = 4;
  localparam int CFG_WIDTH              = 16;
  localparam int CFG_INDEX_WIDTH        = 2;
  localparam int TIME_FIELD_WIDTH       = 32;

  localparam logic [CFG_INDEX_WIDTH-1:0] REG_SAMPLE_PERIOD   = 2'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_TRIGGER_CONFIRM = 2'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_RELEASE_CONFIRM = 2'd2;

  localparam int CH_LEFT_UPPER  = 0;
  localparam int CH_LEFT_LOWER  = 1;
  localparam int CH_RIGHT_UPPER = 2;
  localparam int CH_RIGHT_LOWER = 3;

  localparam logic [CFG_WIDTH-1:0] SAMPLE_PERIOD_RESET   = 16'd5;
  localparam logic [CFG_WIDTH-1:0] TRIGGER_CONFIRM_RESET = 16'd20;
  localparam logic [CFG_WIDTH-1:0] RELEASE_CONFIRM_RESET = 16'd50;

  typedef struct packed {
    logic [TIME_FIELD_WIDTH-1:0] time_ms;
    logic                        raw_left_upper;
    logic                        raw_left_lower;
    logic                        raw_right_upper;
    logic                        raw_right_lower;
    logic                        direction;
  } item_t;

  typedef struct packed {
    logic stable_left_upper;
    logic stable_left_lower;
    logic stable_right_upper;
    logic stable_right_lower;
    logic any_upper_active;
    logic any_lower_active;
    logic upper_mismatch;
    logic lower_mismatch;
    logic side_mismatch;
    logic direction_blocked;
    logic raw_direction_active;
  } result_t;

  typedef struct packed {
    logic load;
    logic step;
  } lane_ctrl_t;

endpackage

### sv/lsdq_lane.sv
// ---------------------------------------------------------------------------
// Limit switch debounce lane
// One channel's filter: candidate level, its start time and the stable
// level, with asymmetric confirm times for set and clear.
// ---------------------------------------------------------------------------
module lsdq_lane #(
  parameter int TIMESTAMP_BITS = lsdq_pkg::TIMESTAMP_BITS_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  lsdq_pkg::lane_ctrl_t           ctrl,
  input  logic                           raw,
  input  logic [TIMESTAMP_BITS-1:0]      now,
  input  logic [lsdq_pkg::CFG_WIDTH-1:0] trigger_confirm,
  input  logic [lsdq_pkg::CFG_WIDTH-1:0] release_confirm,
  output logic                           level_next
);

  logic                      stable;
  logic                      cand;
  logic [TIMESTAMP_BITS-1:0] since;
  logic                      cand_next;
  logic [TIMESTAMP_BITS-1:0] since_next;
  logic [TIMESTAMP_BITS-1:0] held;
  logic [TIMESTAMP_BITS-1:0] need;
  logic                      confirmed;

  assign held      = now - since;
  assign need      = TIMESTAMP_BITS'(raw ? trigger_confirm : release_confirm);
  assign confirmed = held >= need;

  always_comb begin
    level_next = stable;
    cand_next  = cand;
    since_next = since;
    if (ctrl.load) begin
      level_next = raw;
      cand_next  = raw;
      since_next = '0;
    end else if (ctrl.step) begin
      if ((raw == stable) || (raw != cand)) begin
        cand_next  = raw;
        since_next = now;
      end else if (confirmed) begin
        level_next = raw;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stable <= 1'b0;
      cand   <= 1'b0;
      since  <= '0;
    end else begin
      stable <= level_next;
      cand   <= cand_next;
      since  <= since_next;
    end
  end

endmodule

### sv/lsdq_merge.sv
// ---------------------------------------------------------------------------
// Limit switch debounce merge stage
// Combines the four lane levels, the raw levels and the direction into the
// status word and holds it in an output register backed by a skid register.
// ---------------------------------------------------------------------------
`include "limit_switch_debounce_quad_assert.svh"

module lsdq_merge (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                push,
  input  logic [lsdq_pkg::CH_COUNT-1:0]       level,
  input  logic [lsdq_pkg::CH_COUNT-1:0]       raw,
  input  logic                                direction,
  output logic                                full,
  output logic                                result_valid,
  input  logic                                result_stall,
  output lsdq_pkg::result_t                   result
);

  lsdq_pkg::result_t merged;
  lsdq_pkg::result_t skid;
  logic              skid_valid;

  always_comb begin
    merged.stable_left_upper  = level[lsdq_pkg::CH_LEFT_UPPER];
    merged.stable_left_lower  = level[lsdq_pkg::CH_LEFT_LOWER];
    merged.stable_right_upper = level[lsdq_pkg::CH_RIGHT_UPPER];
    merged.stable_right_lower = level[lsdq_pkg::CH_RIGHT_LOWER];
    merged.any_upper_active   = level[lsdq_pkg::CH_LEFT_UPPER] | level[lsdq_pkg::CH_RIGHT_UPPER];
    merged.any_lower_active   = level[lsdq_pkg::CH_LEFT_LOWER] | level[lsdq_pkg::CH_RIGHT_LOWER];
    merged.upper_mismatch     = level[lsdq_pkg::CH_LEFT_UPPER] ^ level[lsdq_pkg::CH_RIGHT_UPPER];
    merged.lower_mismatch     = level[lsdq_pkg::CH_LEFT_LOWER] ^ level[lsdq_pkg::CH_RIGHT_LOWER];
    merged.side_mismatch      = merged.upper_mismatch | merged.lower_mismatch;
    merged.direction_blocked  = direction ? merged.any_upper_active : merged.any_lower_active;
    merged.raw_direction_active = direction ?
        (raw[lsdq_pkg::CH_LEFT_UPPER] | raw[lsdq_pkg::CH_RIGHT_UPPER]) :
        (raw[lsdq_pkg::CH_LEFT_LOWER] | raw[lsdq_pkg::CH_RIGHT_LOWER]);
  end

  assign full = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (result_valid && result_stall) begin
      // hold the output, park a new transfer
      if (push) begin
        skid       <= merged;
        skid_valid <= 1'b1;
      end
    end else if (skid_valid) begin
      result       <= skid;
      result_valid <= 1'b1;
      skid_valid   <= 1'b0;
    end else begin
      result       <= merged;
      result_valid <= push;
    end
  end

  `LSDQ_ASSERT_IMPL(a_skid_behind_out, clk, rst, skid_valid, result_valid)
  `LSDQ_ASSERT_NEVER(a_push_when_full, clk, rst, push && skid_valid)
  `LSDQ_ASSERT_NEXT(a_drain_empty, clk, rst,
                    result_valid && !result_stall && !skid_valid && !push, !result_valid)

endmodule

### sv/limit_switch_debounce_quad.sv
// ---------------------------------------------------------------------------
// Four-channel limit switch debouncer
// Filters left/right upper/lower limit switches with asymmetric set and
// clear confirm times and reports the filtered status per transfer.
// ---------------------------------------------------------------------------
// Usage:
//   item channel   : item_valid / item_stall / item (timestamp, raw levels,
//                    direction). One transfer yields exactly one result.
//   result channel : result_valid / result_stall / result (filtered levels
//                    and derived status).
//   cfg port       : cfg_we / cfg_index / cfg_data, sample period, trigger
//                    and release confirm times; write only while idle.
// Throughput is one item per cycle while item_stall is low: the four lanes
// and the sample timer update in the cycle of the transfer, and the result
// lands in the output register when that register is not stalled.
// A stalled result is held; one further item is parked in the skid
// register, after which item_stall rises until the output drains.
// Reset clears all lanes, the sample timer and the started flag and loads
// the default periods (5, 20, 50 ms); the first item after reset takes its
// raw levels as stable without filtering.
// ---------------------------------------------------------------------------
`include "limit_switch_debounce_quad_assert.svh"

module limit_switch_debounce_quad #(
  parameter int TIMESTAMP_BITS = lsdq_pkg::TIMESTAMP_BITS_DEFAULT
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  item_valid,
  output logic                                  item_stall,
  input  lsdq_pkg::item_t                       item,
  output logic                                  result_valid,
  input  logic                                  result_stall,
  output lsdq_pkg::result_t                     result,
  input  logic                                  cfg_we,
  input  logic [lsdq_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
  input  logic [lsdq_pkg::CFG_WIDTH-1:0]        cfg_data
);

  logic [lsdq_pkg::CFG_WIDTH-1:0] sample_period;
  logic [lsdq_pkg::CFG_WIDTH-1:0] trigger_confirm;
  logic [lsdq_pkg::CFG_WIDTH-1:0] release_confirm;
  logic                           started;
  logic [TIMESTAMP_BITS-1:0]      last_sample;
  logic [TIMESTAMP_BITS-1:0]      now;
  logic [TIMESTAMP_BITS-1:0]      elapsed;
  logic                           accept;
  logic                           full;
  lsdq_pkg::lane_ctrl_t           ctrl;
  logic [lsdq_pkg::CH_COUNT-1:0]  raw;
  logic [lsdq_pkg::CH_COUNT-1:0]  level_next;

  assign item_stall = full;
  assign accept     = item_valid && !full;
  assign now        = TIMESTAMP_BITS'(item.time_ms);
  assign elapsed    = now - last_sample;

  assign ctrl.load = accept && !started;
  assign ctrl.step = accept && started && (elapsed >= TIMESTAMP_BITS'(sample_period));

  assign raw[lsdq_pkg::CH_LEFT_UPPER]  = item.raw_left_upper;
  assign raw[lsdq_pkg::CH_LEFT_LOWER]  = item.raw_left_lower;
  assign raw[lsdq_pkg::CH_RIGHT_UPPER] = item.raw_right_upper;
  assign raw[lsdq_pkg::CH_RIGHT_LOWER] = item.raw_right_lower;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_period   <= lsdq_pkg::SAMPLE_PERIOD_RESET;
      trigger_confirm <= lsdq_pkg::TRIGGER_CONFIRM_RESET;
      release_confirm <= lsdq_pkg::RELEASE_CONFIRM_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        lsdq_pkg::REG_SAMPLE_PERIOD:   sample_period   <= cfg_data;
        lsdq_pkg::REG_TRIGGER_CONFIRM: trigger_confirm <= cfg_data;
        lsdq_pkg::REG_RELEASE_CONFIRM: release_confirm <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      started     <= 1'b0;
      last_sample <= '0;
    end else if (ctrl.load) begin
      started     <= 1'b1;
      last_sample <= '0;
    end else if (ctrl.step) begin
      last_sample <= now;
    end
  end

  for (genvar ch = 0; ch < lsdq_pkg::CH_COUNT; ch++) begin : g_lane
    lsdq_lane #(
      .TIMESTAMP_BITS(TIMESTAMP_BITS)
    ) u_lane (
      .clk            (clk),
      .rst            (rst),
      .ctrl           (ctrl),
      .raw            (raw[ch]),
      .now            (now),
      .trigger_confirm(trigger_confirm),
      .release_confirm(release_confirm),
      .level_next     (level_next[ch])
    );
  end

  lsdq_merge u_merge (
    .clk         (clk),
    .rst         (rst),
    .push        (accept),
    .level       (level_next),
    .raw         (raw),
    .direction   (item.direction),
    .full        (full),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result      (result)
  );

  `LSDQ_ASSERT_NEVER(a_load_and_step, clk, rst, ctrl.load && ctrl.step)
  `LSDQ_ASSERT_NEXT(a_started_after_transfer, clk, rst, accept, started)
  `LSDQ_ASSERT_NEXT(a_transfer_gives_result, clk, rst, accept, result_valid)

endmodule
